### hw/rtl/layered_key_matrix_debouncer_macros.svh
// Assertion macros shared by the debouncer RTL.
`ifndef LAYERED_KEY_MATRIX_DEBOUNCER_MACROS_SVH
`define LAYERED_KEY_MATRIX_DEBOUNCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LKMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lkmd_pkg.sv
// Package with types and constants of the key matrix debouncer.
`timescale 1ns / 1ps
package lkmd_pkg;

  localparam int unsigned CntW  = 8;
  localparam int unsigned ThrW  = 7;
  localparam int unsigned LayW  = 2;
  localparam int unsigned RowW  = 2;
  localparam int unsigned ColW  = 4;

  localparam logic [ThrW-1:0] ThrReset = 7'd5;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdEndScan = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } lkmd_state_e;

endpackage

### hw/rtl/layered_key_matrix_debouncer.sv
// Top level of the layered key matrix debouncer.
// A command beat is taken at a rising edge with start high and busy low.
// With cmd_i low it samples one key: layer_i, row_i, column_i select the
// counter and closed_i gives the switch level. With cmd_i high it decays
// every layer but layer_i by the release rule.
// Each command gives one result beat: done_o is high for one cycle with
// key_active_o and level_o; the receiver cannot stall it.
// A key sample passes from accept through a read state, which reads the counter
// memory, and an update state, which updates, writes back and reports, before the
// next accept. An end-of-scan command walks the whole counter store through the
// same update unit, reading and then updating one counter after another, as the
// memory has a single read and a single write port, both on one address.
// After reset the block clears the counter store, one counter a cycle, with busy
// high; the threshold resets to 5.
// The threshold is written through the cfg channel, which is always ready,
// and is only to be changed while the block is idle.
`timescale 1ns / 1ps
module layered_key_matrix_debouncer import lkmd_pkg::*; #(
  parameter int unsigned ROWS    = 4,
  parameter int unsigned COLUMNS = 11,
  parameter int unsigned LAYERS  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            cmd_i,
  input  logic [LayW-1:0] layer_i,
  input  logic [RowW-1:0] row_i,
  input  logic [ColW-1:0] column_i,
  input  logic            closed_i,
  output logic            done_o,
  output logic            key_active_o,
  output logic [CntW-1:0] level_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ThrW-1:0] cfg_threshold_i
);

`include "layered_key_matrix_debouncer_macros.svh"

  localparam int unsigned Kpl   = ROWS * COLUMNS;
  localparam int unsigned Depth = LAYERS * Kpl;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned KW    = (Kpl > 1) ? $clog2(Kpl) : 1;
  localparam int unsigned LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  lkmd_state_e state_q, state_d;

  logic [ThrW-1:0] thr_q, thr_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [KW-1:0]   key_q, key_d;
  logic [LW-1:0]   lay_q, lay_d;
  logic            cmd_q, cmd_d;
  logic            closed_q, closed_d;
  logic            oor_q, oor_d;
  logic [LayW-1:0] spared_q, spared_d;

  logic            accept;
  logic            in_range;
  logic [AW-1:0]   sample_addr;
  logic            last_entry;
  logic            spared_hit;

  logic            ram_we;
  logic [CntW-1:0] ram_wdata;
  logic [CntW-1:0] ram_rdata;
  logic [CntW-1:0] rule_level;
  logic            rule_active;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign in_range = (32'(layer_i) < LAYERS) && (32'(row_i) < ROWS) &&
                    (32'(column_i) < COLUMNS);
  assign sample_addr = AW'(32'(layer_i) * Kpl + 32'(row_i) * COLUMNS + 32'(column_i));
  assign last_entry  = (32'(addr_q) == Depth - 1);
  assign spared_hit  = (32'(lay_q) == 32'(spared_q));

  lkmd_ram #(
    .WIDTH (CntW),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  lkmd_rule u_rule (
    .level_i  (ram_rdata),
    .thr_i    (thr_q),
    .closed_i (closed_q && (cmd_q == CmdSample)),
    .level_o  (rule_level),
    .active_o (rule_active)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (last_entry) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd_q == CmdSample || last_entry) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    done_o       = 1'b0;
    key_active_o = 1'b0;
    level_o      = '0;
    ram_we       = 1'b0;
    ram_wdata    = rule_level;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_READ: begin
        ram_we = 1'b0;
      end
      ST_UPDATE: begin
        if (cmd_q == CmdSample) begin
          ram_we = !oor_q;
          done_o = 1'b1;
          if (!oor_q) begin
            key_active_o = rule_active;
            level_o      = rule_level;
          end
        end else begin
          ram_we = !spared_hit;
          done_o = last_entry;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    thr_d    = thr_q;
    addr_d   = addr_q;
    key_d    = key_q;
    lay_d    = lay_q;
    cmd_d    = cmd_q;
    closed_d = closed_q;
    oor_d    = oor_q;
    spared_d = spared_q;
    if (cfg_valid_i) begin
      thr_d = cfg_threshold_i;
    end
    case (state_q)
      ST_CLEAR: begin
        addr_d = last_entry ? '0 : addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          closed_d = closed_i;
          oor_d    = !in_range;
          spared_d = layer_i;
          key_d    = '0;
          lay_d    = '0;
          if (cmd_i == CmdSample && in_range) begin
            addr_d = sample_addr;
          end else begin
            addr_d = '0;
          end
        end
      end
      ST_UPDATE: begin
        if (cmd_q == CmdEndScan && !last_entry) begin
          addr_d = addr_q + 1'b1;
          if (32'(key_q) == Kpl - 1) begin
            key_d = '0;
            lay_d = lay_q + 1'b1;
          end else begin
            key_d = key_q + 1'b1;
          end
        end
      end
      default: begin
        addr_d = addr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      thr_q   <= ThrReset;
      addr_q  <= '0;
      key_q   <= '0;
      lay_q   <= '0;
      cmd_q   <= CmdSample;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      thr_q   <= thr_d;
      addr_q  <= addr_d;
      key_q   <= key_d;
      lay_q   <= lay_d;
      cmd_q   <= cmd_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    closed_q <= closed_d;
    spared_q <= spared_d;
  end

  `LKMD_ASSERT_NEXT(a_accept_no_result, clk_i, rst_ni, accept, busy && !done_o,
    "Result beat in the cycle after a command was accepted.")
  `LKMD_ASSERT_NOW(a_eos_zero_result, clk_i, rst_ni, done_o && (cmd_q == CmdEndScan),
    (level_o == '0) && !key_active_o, "End-of-scan result beat is not zero.")
  `LKMD_ASSERT_NOW(a_clear_writes_zero, clk_i, rst_ni, state_q == ST_CLEAR,
    ram_we && (ram_wdata == '0) && !done_o, "Clearing pass does not write zero.")
  `LKMD_ASSERT_NOW(a_oor_no_write, clk_i, rst_ni, done_o && (cmd_q == CmdSample) && oor_q,
    !ram_we && (level_o == '0), "Out-of-range sample touched the counter store.")

endmodule

### hw/rtl/lkmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 176,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lkmd_rule.sv
// Shared counter update unit: press and release rules of the integrator.
`timescale 1ns / 1ps
module lkmd_rule import lkmd_pkg::*; (
  input  logic [CntW-1:0] level_i,
  input  logic [ThrW-1:0] thr_i,
  input  logic            closed_i,
  output logic [CntW-1:0] level_o,
  output logic            active_o
);

  logic [CntW-1:0] thr_ext;

  assign thr_ext = {1'b0, thr_i};

  always_comb begin
    if (closed_i) begin
      if (level_i >= thr_ext) begin
        level_o = {thr_i, 1'b0};
      end else begin
        level_o = level_i + 8'd1;
      end
    end else begin
      if (level_i > thr_ext) begin
        level_o = level_i - 8'd1;
      end else begin
        level_o = '0;
      end
    end
  end

  assign active_o = (level_o >= thr_ext);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the layered key matrix debouncer.
`timescale 1ns / 1ps
module tb_top;
  import lkmd_pkg::*;

  localparam int unsigned NumRows = 4;
  localparam int unsigned NumColumns = 11;
  localparam int unsigned NumLayers = 4;
  localparam int unsigned KeysPerLayer = NumRows * NumColumns;
  localparam int unsigned ItemsPerPhase = 226;
  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic            cmd;
    logic [LayW-1:0] layer;
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic            closed;
  } scan_cmd_t;

  typedef struct packed {
    logic            key_active;
    logic [CntW-1:0] level;
  } key_report_t;

  typedef struct packed {
    scan_cmd_t   c;
    logic        typed;
    key_report_t r;
  } script_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic            cmd_i;
  logic [LayW-1:0] layer_i;
  logic [RowW-1:0] row_i;
  logic [ColW-1:0] column_i;
  logic            closed_i;
  logic            done_o;
  logic            key_active_o;
  logic [CntW-1:0] level_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [ThrW-1:0] cfg_threshold_i;

  logic [CntW-1:0] key_level [NumLayers*KeysPerLayer];
  logic [ThrW-1:0] threshold;
  key_report_t     pending_reports [$];
  key_report_t     oldest;
  int unsigned     fails = 0;
  int unsigned     quiet = 0;

  layered_key_matrix_debouncer #(
    .ROWS    (NumRows),
    .COLUMNS (NumColumns),
    .LAYERS  (NumLayers)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .layer_i         (layer_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .closed_i        (closed_i),
    .done_o          (done_o),
    .key_active_o    (key_active_o),
    .level_o         (level_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_threshold_i (cfg_threshold_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [CntW-1:0] release_level(input logic [CntW-1:0] v);
    if (v > {1'b0, threshold}) begin
      return v - 8'd1;
    end
    return '0;
  endfunction

  function automatic key_report_t advance_counters(input scan_cmd_t c);
    key_report_t     r;
    int unsigned     idx;
    logic [CntW-1:0] v;
    r = '0;
    if (c.cmd == CmdEndScan) begin
      for (int l = 0; l < NumLayers; l++) begin
        if (l != c.layer) begin
          for (int k = 0; k < KeysPerLayer; k++) begin
            key_level[l*KeysPerLayer+k] = release_level(key_level[l*KeysPerLayer+k]);
          end
        end
      end
    end else if (c.layer < NumLayers && c.row < NumRows && c.column < NumColumns) begin
      idx = c.layer * KeysPerLayer + c.row * NumColumns + c.column;
      v = key_level[idx];
      if (c.closed) begin
        v = (v >= {1'b0, threshold}) ? {threshold, 1'b0} : v + 8'd1;
      end else begin
        v = release_level(v);
      end
      key_level[idx] = v;
      r.key_active = (v >= {1'b0, threshold});
      r.level = v;
    end
    return r;
  endfunction

  task automatic send_cmd(input scan_cmd_t c, input logic typed, input key_report_t fixed,
                          input int idle_pct);
    key_report_t want;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start    <= 1'b1;
    cmd_i    <= c.cmd;
    layer_i  <= c.layer;
    row_i    <= c.row;
    column_i <= c.column;
    closed_i <= c.closed;
    do @(posedge clk_i); while (busy);
    want = advance_counters(c);
    if (typed) begin
      want = fixed;
    end
    pending_reports.push_back(want);
  endtask

  // Threshold writes wait until every report is back and the block is idle.
  task automatic write_threshold(input logic [ThrW-1:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0 || busy);
    cfg_valid_i     <= 1'b1;
    cfg_threshold_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: key_active=%0d level=%0d", key_active_o, level_o);
        fails++;
      end else begin
        oldest = pending_reports.pop_front();
        if (key_active_o !== oldest.key_active) begin
          $error("key_active: expected %0d, got %0d", oldest.key_active, key_active_o);
          fails++;
        end
        if (level_o !== oldest.level) begin
          $error("level: expected %0d, got %0d", oldest.level, level_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t     script [20];
    scan_cmd_t       item;
    scan_cmd_t       burst_key;
    scan_cmd_t       pool [4];
    logic [ThrW-1:0] thr_plan [5];
    int              idle_plan [5];
    int              roll;
    int              burst_left;

    rst_ni          = 1'b0;
    start           <= 1'b0;
    cmd_i           <= CmdSample;
    layer_i         <= '0;
    row_i           <= '0;
    column_i        <= '0;
    closed_i        <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_threshold_i <= '0;
    threshold       = ThrReset;
    foreach (key_level[i]) key_level[i] = '0;

    script = '{
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b1, '{1'b0, 8'd1}},
      '{'{CmdSample,  2'd3, 2'd3, 4'd10, 1'b0}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdSample,  2'd3, 2'd3, 4'd10, 1'b1}, 1'b1, '{1'b0, 8'd1}},
      '{'{CmdSample,  2'd0, 2'd0, 4'd15, 1'b1}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdSample,  2'd2, 2'd1, 4'd11, 1'b0}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdEndScan, 2'd0, 2'd3, 4'd15, 1'b1}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b0}, 1'b0, '0},
      '{'{CmdEndScan, 2'd1, 2'd0, 4'd0,  1'b0}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b0}, 1'b0, '0},
      '{'{CmdEndScan, 2'd0, 2'd0, 4'd0,  1'b0}, 1'b1, '{1'b0, 8'd0}},
      '{'{CmdSample,  2'd0, 2'd0, 4'd0,  1'b0}, 1'b0, '0},
      '{'{CmdSample,  2'd3, 2'd3, 4'd10, 1'b1}, 1'b0, '0},
      '{'{CmdSample,  2'd1, 2'd2, 4'd5,  1'b1}, 1'b0, '0},
      '{'{CmdEndScan, 2'd3, 2'd1, 4'd7,  1'b0}, 1'b1, '{1'b0, 8'd0}}
    };
    thr_plan  = '{7'd1, 7'd127, 7'd0, 7'($urandom_range(2, 12)), ThrReset};
    idle_plan = '{0, 67, 0, 15, 67};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      send_cmd(script[i].c, script[i].typed, script[i].r, 0);
    end

    // Most traffic presses and releases a few keys in runs, the longest long enough to
    // reach and leave the hold level; scan ends and off-matrix samples are mixed in.
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_plan[p]);
      for (int i = 0; i < 4; i++) begin
        pool[i] = '{CmdSample, 2'($urandom_range(3)), 2'($urandom_range(3)),
                    4'($urandom_range(NumColumns - 1)), 1'b0};
      end
      burst_left = 0;
      burst_key  = pool[0];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(3) != 0) begin
            burst_key = pool[$urandom_range(3)];
          end else begin
            burst_key = '{CmdSample, 2'($urandom_range(3)), 2'($urandom_range(3)),
                          4'($urandom_range(NumColumns - 1)), 1'b0};
          end
          burst_key.closed = 1'($urandom_range(1));
          burst_left = burst_key.closed ? $urandom_range(1, thr_plan[p] + 6)
                                        : $urandom_range(1, thr_plan[p] + 4);
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
          item = '{CmdEndScan, $urandom_range(1) ? burst_key.layer : 2'($urandom_range(3)),
                   2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom_range(1))};
        end else if (roll < 8) begin
          item = '{CmdSample, 2'($urandom_range(3)), 2'($urandom_range(3)),
                   4'($urandom_range(NumColumns, 15)), 1'($urandom_range(1))};
        end else begin
          item = burst_key;
          burst_left--;
        end
        send_cmd(item, 1'b0, '0, idle_plan[p]);
      end
    end

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lkmd_pkg.sv
hw/rtl/lkmd_ram.sv
hw/rtl/lkmd_rule.sv
hw/rtl/layered_key_matrix_debouncer.sv
tb/tb_top.sv
